FILE: hw/rtl/gda_pkg.sv
// ----------------------------------------------------------------------------
// Gregorian date advance package
// Shared types, constants and calendar functions for the date advance unit.
// ----------------------------------------------------------------------------
package gda_pkg;

	localparam logic [15:0] YEAR_MAX      = 16'hFFFF;
	localparam logic [8:0]  QUAD_CENT     = 9'd400;
	localparam logic [8:0]  QUAD_LAST     = 9'd399;
	localparam logic [8:0]  CENT_ONE      = 9'd100;
	localparam logic [8:0]  CENT_TWO      = 9'd200;
	localparam logic [8:0]  CENT_THREE    = 9'd300;
	localparam logic [3:0]  MON_JAN       = 4'd1;
	localparam logic [3:0]  MON_FEB       = 4'd2;
	localparam logic [3:0]  MON_APR       = 4'd4;
	localparam logic [3:0]  MON_JUN       = 4'd6;
	localparam logic [3:0]  MON_SEP       = 4'd9;
	localparam logic [3:0]  MON_NOV       = 4'd11;
	localparam logic [3:0]  MON_DEC       = 4'd12;
	localparam logic [4:0]  DAY_FIRST     = 5'd1;
	localparam logic [4:0]  DAY_LAST      = 5'd31;
	localparam logic [11:0] DIV25_MUL     = 12'd2622;
	localparam int unsigned MOD_IDX_BITS  = 1;

	localparam logic [MOD_IDX_BITS-1:0] MOD_QUOT = 1'b0;
	localparam logic [MOD_IDX_BITS-1:0] MOD_REM  = 1'b1;

	typedef struct packed {
		logic                    load;
		logic                    mod_step;
		logic [MOD_IDX_BITS-1:0] mod_idx;
		logic                    clamp;
		logic                    walk;
	} gda_cmd_t;

	typedef struct packed {
		logic left_zero;
	} gda_status_t;

	// Leap test from the year taken modulo 400.
	function automatic logic leap_from_mod(input logic [8:0] m400);
		logic by_four;
		logic on_cent;
		by_four = (m400[1:0] == 2'b00);
		on_cent = (m400 == 9'd0) || (m400 == CENT_ONE) || (m400 == CENT_TWO)
			|| (m400 == CENT_THREE);
		return (by_four && !on_cent) || (m400 == 9'd0);
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		if (mon == MON_FEB) begin
			len = leap ? 5'd29 : 5'd28;
		end else if ((mon == MON_APR) || (mon == MON_JUN) || (mon == MON_SEP)
			|| (mon == MON_NOV)) begin
			len = 5'd30;
		end else begin
			len = 5'd31;
		end
		return len;
	endfunction

endpackage

FILE: hw/rtl/gda_datapath.sv
// ----------------------------------------------------------------------------
// Gregorian date advance datapath
// Holds the date, the remaining day count and the year modulo 400. The year
// is reduced modulo 400 in two steps by a reciprocal multiply, the day is
// clamped, then one month step is performed per cycle on command.
// ----------------------------------------------------------------------------
module gda_datapath
	import gda_pkg::*;
#(
	parameter int unsigned DAYS_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gda_cmd_t             cmd,
	input  logic [4:0]           start_day,
	input  logic [3:0]           start_month,
	input  logic [15:0]          start_year,
	input  logic [DAYS_BITS-1:0] days_to_add,
	output gda_status_t          status,
	output logic [4:0]           end_day,
	output logic [3:0]           end_month,
	output logic [15:0]          end_year,
	output logic                 year_overflow
);

	logic [4:0]           day_q;
	logic [3:0]           mon_q;
	logic [15:0]          yr_q;
	logic [DAYS_BITS-1:0] left_q;
	logic                 ovf_q;
	logic [8:0]           m400_q;
	logic [7:0]           quot_q;

	logic                 leap;
	logic [4:0]           len;
	logic [DAYS_BITS:0]   reach;
	logic [4:0]           consume;
	logic [23:0]          quot_prod;
	logic [15:0]          quot_x400;

	assign leap      = leap_from_mod(m400_q);
	assign len       = month_len(mon_q, leap);
	assign reach     = {{(DAYS_BITS-4){1'b0}}, day_q} + {1'b0, left_q};
	assign consume   = len - day_q + DAY_FIRST;
	assign quot_prod = {12'd0, yr_q[15:4]} * {12'd0, DIV25_MUL};
	assign quot_x400 = {8'd0, quot_q} * {7'd0, QUAD_CENT};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q  <= DAY_FIRST;
			mon_q  <= MON_JAN;
			yr_q   <= '0;
			left_q <= '0;
			ovf_q  <= 1'b0;
			m400_q <= '0;
			quot_q <= '0;
		end else if (cmd.load) begin
			day_q  <= (start_day == 5'd0) ? DAY_FIRST : start_day;
			mon_q  <= (start_month == 4'd0) ? MON_JAN :
				((start_month > MON_DEC) ? MON_DEC : start_month);
			yr_q   <= start_year;
			left_q <= days_to_add;
			ovf_q  <= 1'b0;
			m400_q <= '0;
		end else if (cmd.mod_step) begin
			if (cmd.mod_idx == MOD_QUOT) begin
				quot_q <= quot_prod[23:16];
			end else begin
				m400_q <= yr_q[8:0] - quot_x400[8:0];
			end
		end else if (cmd.clamp) begin
			if (day_q > len) begin
				day_q <= len;
			end
		end else if (cmd.walk) begin
			if (reach > {{(DAYS_BITS-4){1'b0}}, len}) begin
				left_q <= left_q - {{(DAYS_BITS-5){1'b0}}, consume};
				day_q  <= DAY_FIRST;
				if (mon_q == MON_DEC) begin
					if (yr_q == YEAR_MAX) begin
						ovf_q  <= 1'b1;
						day_q  <= DAY_LAST;
						left_q <= '0;
					end else begin
						mon_q  <= MON_JAN;
						yr_q   <= yr_q + 16'd1;
						m400_q <= (m400_q == QUAD_LAST) ? 9'd0 : m400_q + 9'd1;
					end
				end else begin
					mon_q <= mon_q + 4'd1;
				end
			end else begin
				day_q  <= day_q + left_q[4:0];
				left_q <= '0;
			end
		end
	end

	assign status.left_zero = (left_q == '0);
	assign end_day          = day_q;
	assign end_month        = mon_q;
	assign end_year         = yr_q;
	assign year_overflow    = ovf_q;

endmodule

FILE: hw/rtl/gda_controller.sv
// ----------------------------------------------------------------------------
// Gregorian date advance controller
// Sequences load, year reduction, day clamp and the month walk, and drives
// the busy and done handshake signals.
// ----------------------------------------------------------------------------
module gda_controller
	import gda_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  gda_status_t status,
	output gda_cmd_t    cmd,
	output logic        busy,
	output logic        done
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_CLAMP,
		S_WALK,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [MOD_IDX_BITS-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic                    accept;

	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= MOD_QUOT;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE, S_DONE: begin
					if (accept) begin
						state_q <= S_MOD;
						cnt_q   <= MOD_QUOT;
						busy_q  <= 1'b1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MOD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == MOD_REM) begin
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (status.left_zero) begin
						state_q <= S_DONE;
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.mod_step = (state_q == S_MOD);
		cmd.mod_idx  = cnt_q;
		cmd.clamp    = (state_q == S_CLAMP);
		cmd.walk     = (state_q == S_WALK) && !status.left_zero;
	end

	assign busy = busy_q;
	assign done = done_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done raised while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && !status.left_zero) |=> busy)
		else $error("busy dropped while days remain");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

endmodule

FILE: hw/rtl/gregorian_date_advance_unit.sv
// ----------------------------------------------------------------------------
// Gregorian date advance unit
// Adds a day count to a Gregorian date, walking one month per cycle.
// ----------------------------------------------------------------------------
// A transaction is accepted at a rising edge where start is high and busy is
// low; start_day, start_month, start_year and days_to_add are sampled then.
// The result appears on end_day, end_month, end_year and year_overflow for
// exactly one cycle, marked by done; the receiver cannot stall it, and the
// result ports keep their value until the next transaction is accepted.
// After acceptance the year is reduced modulo 400 by a reciprocal multiply,
// the day is clamped, the walk advances one month per step, and then done is
// raised. The walk takes one step per month boundary crossed plus one when
// days remain inside the last month. Only one transaction is in flight; the
// next one may be accepted in the cycle that shows done. Out-of-range months
// and days are corrected before the walk, and a year past 65535 saturates at
// 31 December 65535 with year_overflow set. Reset returns the controller to
// idle with busy low.
// ----------------------------------------------------------------------------
module gregorian_date_advance_unit
	import gda_pkg::*;
#(
	parameter int unsigned DAYS_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [4:0]           start_day,
	input  logic [3:0]           start_month,
	input  logic [15:0]          start_year,
	input  logic [DAYS_BITS-1:0] days_to_add,
	output logic                 done,
	output logic [4:0]           end_day,
	output logic [3:0]           end_month,
	output logic [15:0]          end_year,
	output logic                 year_overflow
);

	gda_cmd_t    cmd;
	gda_status_t status;

	gda_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gda_datapath #(
		.DAYS_BITS (DAYS_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.start_day     (start_day),
		.start_month   (start_month),
		.start_year    (start_year),
		.days_to_add   (days_to_add),
		.status        (status),
		.end_day       (end_day),
		.end_month     (end_month),
		.end_year      (end_year),
		.year_overflow (year_overflow)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (end_month >= MON_JAN) && (end_month <= MON_DEC))
		else $error("result month out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (end_day != 5'd0))
		else $error("result day is zero");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && year_overflow) |-> (end_year == YEAR_MAX) && (end_day == DAY_LAST))
		else $error("overflow result not saturated");

endmodule

FILE: tb/sv/gregorian_date_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gregorian date advance result checker
// Watches the command and result ports of the date advance unit. Each
// accepted transaction has its resulting date computed here and queued. Each
// done strobe is compared, field by field, with the oldest queued date.
// ----------------------------------------------------------------------------
module gregorian_date_checker
	import gda_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [4:0]  start_day,
	input  logic [3:0]  start_month,
	input  logic [15:0] start_year,
	input  logic [15:0] days_to_add,
	input  logic        done,
	input  logic [4:0]  end_day,
	input  logic [3:0]  end_month,
	input  logic [15:0] end_year,
	input  logic        year_overflow,
	output int          failures,
	output int          outstanding,
	output int          checked,
	output int          saturated
);

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [15:0] year;
		logic        overflow;
	} calendar_date_t;

	calendar_date_t expected_dates[$];

	function automatic bit is_leap_year(input int unsigned yr);
		return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
	endfunction

	function automatic int unsigned month_day_count(input int unsigned mon,
		input int unsigned yr);
		if (mon == MON_FEB)
			return is_leap_year(yr) ? 29 : 28;
		if (mon == MON_APR || mon == MON_JUN || mon == MON_SEP || mon == MON_NOV)
			return 30;
		return 31;
	endfunction

	function automatic calendar_date_t advance_date(input logic [4:0] d, input logic [3:0] m,
		input logic [15:0] y, input logic [15:0] n);
		int unsigned day;
		int unsigned mon;
		int unsigned yr;
		int unsigned left;
		int unsigned len;
		calendar_date_t res;
		day = 32'(d);
		mon = 32'(m);
		yr = 32'(y);
		left = 32'(n);
		res.overflow = 1'b0;
		if (mon == 0)
			mon = 32'(MON_JAN);
		if (mon > MON_DEC)
			mon = 32'(MON_DEC);
		if (day == 0)
			day = 32'(DAY_FIRST);
		len = month_day_count(mon, yr);
		if (day > len)
			day = len;
		while (left > 0) begin
			len = month_day_count(mon, yr);
			if (day + left > len) begin
				left = left - (len - day + 1);
				day = 32'(DAY_FIRST);
				if (mon == MON_DEC) begin
					if (yr >= YEAR_MAX) begin
						res.overflow = 1'b1;
						day = 32'(DAY_LAST);
						yr = 32'(YEAR_MAX);
						left = 0;
					end else begin
						mon = 32'(MON_JAN);
						yr++;
					end
				end else begin
					mon++;
				end
			end else begin
				day = day + left;
				left = 0;
			end
		end
		res.day = day[4:0];
		res.month = mon[3:0];
		res.year = yr[15:0];
		return res;
	endfunction

	function automatic int field_mismatch(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			return 1;
		end
		return 0;
	endfunction

	initial begin
		failures = 0;
		checked = 0;
		saturated = 0;
		outstanding = 0;
	end

	always @(posedge clk) begin
		calendar_date_t want;
		if (!arst_n) begin
			expected_dates.delete();
			outstanding <= 0;
		end else begin
			if (done) begin
				if (expected_dates.size() == 0) begin
					$display("%0t: result with no transaction outstanding, actual %0d-%0d-%0d ovf %0d",
						$time, end_year, end_month, end_day, year_overflow);
					failures++;
				end else begin
					want = expected_dates.pop_front();
					failures += field_mismatch("end_day", want.day, end_day);
					failures += field_mismatch("end_month", want.month, end_month);
					failures += field_mismatch("end_year", want.year, end_year);
					failures += field_mismatch("year_overflow", want.overflow, year_overflow);
					checked++;
					if (want.overflow)
						saturated++;
				end
			end
			if (start && !busy)
				expected_dates.push_back(advance_date(start_day, start_month, start_year,
					days_to_add));
			outstanding <= expected_dates.size();
		end
	end

endmodule

FILE: tb/sv/gregorian_date_advance_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gregorian date advance unit testbench
// Drives directed calendar corner cases and then random dates and day counts
// into the unit with random idle cycles; a checker beside the unit predicts
// and compares every result and reports its failure count for the verdict.
// ----------------------------------------------------------------------------
module gregorian_date_advance_unit_test;

	import gda_pkg::*;

	localparam int RANDOM_DATES = 250;
	localparam int CYCLE_LIMIT  = 2500000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [4:0]  start_day;
	logic [3:0]  start_month;
	logic [15:0] start_year;
	logic [15:0] days_to_add;
	logic        done;
	logic [4:0]  end_day;
	logic [3:0]  end_month;
	logic [15:0] end_year;
	logic        year_overflow;

	int failures;
	int outstanding;
	int checked;
	int saturated;
	int cycle_count;
	int sent_count;
	bit idle_enable;

	gregorian_date_advance_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.start_day(start_day),
		.start_month(start_month),
		.start_year(start_year),
		.days_to_add(days_to_add),
		.done(done),
		.end_day(end_day),
		.end_month(end_month),
		.end_year(end_year),
		.year_overflow(year_overflow)
	);

	gregorian_date_checker date_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.start_day(start_day),
		.start_month(start_month),
		.start_year(start_year),
		.days_to_add(days_to_add),
		.done(done),
		.end_day(end_day),
		.end_month(end_month),
		.end_year(end_year),
		.year_overflow(year_overflow),
		.failures(failures),
		.outstanding(outstanding),
		.checked(checked),
		.saturated(saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
				outstanding);
			$display("gregorian_date_advance_unit_test NOT OK");
			$finish;
		end
	end

	task automatic send_date(input logic [4:0] d, input logic [3:0] m, input logic [15:0] y,
		input logic [15:0] n);
		while (idle_enable && ($urandom_range(0, 99) < 22)) begin
			start       <= 1'b0;
			start_day   <= 5'($urandom_range(0, 31));
			start_month <= 4'($urandom_range(0, 15));
			start_year  <= 16'($urandom);
			days_to_add <= 16'($urandom);
			@(posedge clk);
		end
		start       <= 1'b1;
		start_day   <= d;
		start_month <= m;
		start_year  <= y;
		days_to_add <= n;
		do @(posedge clk); while (busy);
		sent_count++;
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		int directed_count;
		int r;
		logic [4:0]  d;
		logic [3:0]  m;
		logic [15:0] y;
		logic [15:0] n;
		sent_count  = 0;
		idle_enable = 1'b1;
		arst_n      <= 1'b0;
		start       <= 1'b0;
		start_day   <= DAY_FIRST;
		start_month <= MON_JAN;
		start_year  <= '0;
		days_to_add <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_date(5'd1, MON_JAN, 16'd0, 16'd0);
		send_date(DAY_LAST, MON_DEC, YEAR_MAX, 16'd0);
		send_date(DAY_LAST, MON_DEC, YEAR_MAX, 16'd1);
		send_date(DAY_LAST, 4'd15, YEAR_MAX, 16'hFFFF);
		send_date(5'd0, 4'd0, 16'd2000, 16'd0);
		send_date(DAY_LAST, 4'd13, 16'd1999, 16'd0);
		send_date(5'd0, 4'd15, 16'd0, 16'hFFFF);
		send_date(DAY_LAST, MON_FEB, 16'd2000, 16'd0);
		send_date(DAY_LAST, MON_FEB, 16'd1900, 16'd0);
		send_date(5'd30, MON_FEB, 16'd2024, 16'd0);
		send_date(5'd29, MON_FEB, 16'd2023, 16'd0);
		send_date(DAY_LAST, MON_APR, 16'd2023, 16'd1);
		send_date(5'd28, MON_FEB, 16'd2024, 16'd1);
		send_date(5'd28, MON_FEB, 16'd2100, 16'd1);
		send_date(5'd28, MON_FEB, 16'd2400, 16'd1);
		send_date(DAY_LAST, MON_DEC, 16'd1999, 16'd1);
		send_date(DAY_LAST, MON_JAN, 16'd2023, 16'd28);
		send_date(5'd1, MON_JAN, 16'd2000, 16'hFFFF);
		send_date(5'd15, MON_JUN, 16'd65400, 16'hFFFF);
		send_date(5'd1, MON_JAN, YEAR_MAX, 16'd364);
		send_date(5'd1, MON_JAN, YEAR_MAX, 16'd365);
		send_date(5'd30, MON_NOV, 16'd65534, 16'h8000);
		send_date(DAY_LAST, MON_SEP, 16'h5555, 16'h5555);
		send_date(5'd10, MON_JUN, 16'hAAAA, 16'h2AAA);
		directed_count = sent_count;
		wait_for_results();

		for (int i = 0; i < RANDOM_DATES; i++) begin
			idle_enable = !(i >= 120 && i < 170);
			if (i == 200)
				wait_for_results();
			r = $urandom_range(0, 99);
			if (r < 75) begin
				d = 5'($urandom_range(1, 28));
				m = 4'($urandom_range(MON_JAN, MON_DEC));
			end else if (r < 90) begin
				d = 5'($urandom_range(0, 31));
				m = 4'($urandom_range(MON_JAN, MON_DEC));
			end else begin
				d = 5'($urandom_range(0, 31));
				m = 4'($urandom_range(0, 15));
			end
			r = $urandom_range(0, 99);
			if (r < 50)
				y = 16'($urandom_range(1583, 2500));
			else if (r < 75)
				y = 16'($urandom);
			else if (r < 90)
				y = 16'($urandom_range(65400, 65535));
			else
				y = 16'($urandom_range(0, 655) * 100);
			r = $urandom_range(0, 99);
			if (r < 55)
				n = 16'($urandom_range(0, 400));
			else if (r < 80)
				n = 16'($urandom_range(0, 4000));
			else if (r < 95)
				n = 16'($urandom);
			else
				n = 16'(16'hFFFF - $urandom_range(0, 3));
			send_date(d, m, y, n);
		end
		wait_for_results();
		repeat (25) @(posedge clk);

		$display("Ran %0d date transactions (%0d directed, %0d random) in %0d cycles.",
			sent_count, directed_count, sent_count - directed_count, cycle_count);
		$display("Checked %0d results, %0d of them saturated at the top year.", checked,
			saturated);
		if (failures == 0 && outstanding == 0) begin
			$display("gregorian_date_advance_unit_test OK");
		end else begin
			$display("gregorian_date_advance_unit_test NOT OK");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/gda_pkg.sv
hw/rtl/gda_datapath.sv
hw/rtl/gda_controller.sv
hw/rtl/gregorian_date_advance_unit.sv
tb/sv/gregorian_date_checker.sv
tb/sv/gregorian_date_advance_unit_test.sv
